// File: rtl/usb_standard_request_responder_unit_macros.svh
// Assertion macros for the USB standard request responder.
// Included by the top level; no other dependencies.
`ifndef USB_STANDARD_REQUEST_RESPONDER_UNIT_MACROS_SVH
`define USB_STANDARD_REQUEST_RESPONDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define USRR_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("usrr assertion failed");
`define USRR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("usrr assertion failed");
`else
`define USRR_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define USRR_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// File: rtl/usrr_pkg.sv
// Package for the USB standard request responder: transaction types, codes,
// descriptor ROM contents and lookup functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usrr_pkg;

  localparam int unsigned MAX_RESULTS = 17;
  localparam int unsigned BEAT_W      = 5;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned DEV_BYTES   = 18;
  localparam int unsigned CFG_BYTES   = 67;
  localparam int unsigned STR_WORDS   = 68;

  typedef logic [POS_W-1:0] pos_t;

  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;
  localparam logic [7:0] DT_STRING = 8'd3;
  localparam logic [7:0] STR_INDEX_MAX = 8'd4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_UNSUP = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef enum logic [2:0] {
    DESC_DEVICE,
    DESC_CONFIG,
    DESC_STR_LANG,
    DESC_STR_MANU,
    DESC_STR_PROD,
    DESC_STR_SERIAL,
    DESC_STR_CONFIG
  } desc_id_t;

  typedef struct packed {
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  response_kind;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_beat;
    logic [6:0]  device_address;
  } rsp_t;

  // Device descriptor followed by configuration descriptor.
  localparam logic [7:0] DEV_CFG_ROM [DEV_BYTES + CFG_BYTES] = '{
    8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00, 8'h40, 8'h50, 8'h1d,
    8'ha7, 8'h60, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01,
    8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0,
    8'h32, 8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02,
    8'h01, 8'h00, 8'h05, 8'h24, 8'h00, 8'h10, 8'h01, 8'h05,
    8'h24, 8'h01, 8'h00, 8'h01, 8'h04, 8'h24, 8'h02, 8'h02,
    8'h05, 8'h24, 8'h06, 8'h00, 8'h01, 8'h07, 8'h05, 8'h82,
    8'h03, 8'h08, 8'h00, 8'hFF, 8'h09, 8'h04, 8'h01, 8'h00,
    8'h02, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h07, 8'h05, 8'h01,
    8'h02, 8'h40, 8'h00, 8'h00, 8'h07, 8'h05, 8'h81, 8'h02,
    8'h40, 8'h00, 8'h00
  };

  // String descriptors as 16-bit words, sent low byte first.
  localparam logic [15:0] STR_ROM [STR_WORDS] = '{
    16'h0304, 16'h0409,
    16'h031E, 16'h004F, 16'h0070, 16'h0065, 16'h006E, 16'h006D, 16'h006F,
    16'h006B, 16'h006F, 16'h002C, 16'h0020, 16'h0049, 16'h006E, 16'h0063,
    16'h002E,
    16'h0332, 16'h0048, 16'h0079, 16'h0064, 16'h0072, 16'h0061, 16'h0042,
    16'h0075, 16'h0073, 16'h0020, 16'h0031, 16'h002E, 16'h0030, 16'h0020,
    16'h0043, 16'h004F, 16'h004D, 16'h0020, 16'h0050, 16'h006F, 16'h0072,
    16'h0074, 16'h0032,
    16'h0336, 16'h0030, 16'h0030, 16'h0033, 16'h0037, 16'h0030, 16'h0030,
    16'h0031, 16'h0045, 16'h0033, 16'h0034, 16'h0033, 16'h0036, 16'h0035,
    16'h0031, 16'h0031, 16'h0031, 16'h0033, 16'h0039, 16'h0033, 16'h0033,
    16'h0033, 16'h0034, 16'h0033, 16'h0034,
    16'h0306, 16'h0030, 16'h0031
  };

  function automatic pos_t desc_size(desc_id_t id);
    pos_t s;
    case (id)
      DESC_DEVICE:     s = pos_t'(DEV_BYTES);
      DESC_CONFIG:     s = pos_t'(CFG_BYTES);
      DESC_STR_LANG:   s = pos_t'(4);
      DESC_STR_MANU:   s = pos_t'(30);
      DESC_STR_PROD:   s = pos_t'(46);
      DESC_STR_SERIAL: s = pos_t'(50);
      DESC_STR_CONFIG: s = pos_t'(6);
      default:         s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] str_base(desc_id_t id);
    logic [6:0] b;
    case (id)
      DESC_STR_MANU:   b = 7'd2;
      DESC_STR_PROD:   b = 7'd17;
      DESC_STR_SERIAL: b = 7'd40;
      DESC_STR_CONFIG: b = 7'd65;
      default:         b = 7'd0;
    endcase
    return b;
  endfunction

  // One descriptor byte; zero past the end of the descriptor.
  function automatic logic [7:0] desc_byte(desc_id_t id, pos_t pos);
    logic [6:0]  widx;
    logic [15:0] w;
    logic [7:0]  b;
    b    = '0;
    w    = '0;
    widx = str_base(id) + {1'b0, pos[POS_W-1:1]};
    if (widx < 7'(STR_WORDS)) begin
      w = STR_ROM[widx];
    end
    if (pos < desc_size(id)) begin
      case (id)
        DESC_DEVICE: b = DEV_CFG_ROM[pos];
        DESC_CONFIG: b = DEV_CFG_ROM[pos_t'(DEV_BYTES) + pos];
        default:     b = pos[0] ? w[15:8] : w[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/usrr_desc_rom.sv
// Descriptor ROM with a registered read port, one beat wide.
// Depends on usrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usrr_desc_rom #(
  parameter int unsigned BYTES_PER_BEAT = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire usrr_pkg::desc_id_t                    id,
  input  wire usrr_pkg::pos_t                        pos,
  input  wire logic [$clog2(BYTES_PER_BEAT+1)-1:0]   nbytes,
  output logic [31:0]                                data_word
);
  import usrr_pkg::*;

  localparam int unsigned CNT_W = $clog2(BYTES_PER_BEAT + 1);
  // Only the first four bytes of a beat fit in the data word.
  localparam int unsigned LANES = (BYTES_PER_BEAT < 4) ? BYTES_PER_BEAT : 4;

  logic [31:0] data_next;

  always_comb begin
    data_next = '0;
    for (int i = 0; i < LANES; i++) begin
      if (CNT_W'(i) < nbytes) begin
        data_next[8*i +: 8] = desc_byte(id, pos + pos_t'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_word <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/usb_standard_request_responder_unit.sv
// First response beat: the request context is registered on the request transaction, then the beat
// is loaded into the response register and the ROM read register. Throughput: one beat per cycle
//   while the sink is ready; an empty packet is one beat, and the 67-byte configuration descriptor
//   is 17 beats at four bytes a beat, all read through the single registered descriptor ROM read port.
// Reset: synchronous; clears the FSM, response valid and the stored address to 0.
`timescale 1ns / 1ps
`default_nettype none

`include "usb_standard_request_responder_unit_macros.svh"

module usb_standard_request_responder_unit #(
  parameter int unsigned BYTES_PER_BEAT = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           request_valid,
  output logic                request_ready,
  input  wire usrr_pkg::req_t request,
  output logic                response_valid,
  input  wire logic           response_ready,
  output usrr_pkg::rsp_t      response
);
  import usrr_pkg::*;

  localparam int unsigned CNT_W = $clog2(BYTES_PER_BEAT + 1);
  localparam pos_t        BPB   = pos_t'(BYTES_PER_BEAT);

  // Control
  state_t state, state_next;
  logic   load;          // move the next beat into the response register
  logic   req_fire;

  // Per-request context, captured on the request transaction
  desc_id_t          id;
  pos_t              pos;       // next descriptor byte to send
  pos_t              remain;    // bytes still to send
  logic [BEAT_W-1:0] beat_cnt;
  logic [1:0]        kind;
  logic [6:0]        stored_address;

  // Request decode
  desc_id_t  dec_id;
  logic      dec_known;
  pos_t      dec_size;
  pos_t      dec_total;
  logic [7:0] dec_type;
  logic [7:0] dec_index;

  // Beat formation
  logic [CNT_W-1:0] nbytes;
  logic             beat_last;

  // Response register (data word comes from the ROM's read register)
  logic [1:0]  rsp_kind;
  logic [2:0]  rsp_count;
  logic        rsp_last;
  logic [6:0]  rsp_addr;
  logic [31:0] rom_data;

  assign req_fire = request_valid & request_ready;

  // ---------------------------------------------------------------------
  // Request decode: descriptor type / string index to descriptor id
  // ---------------------------------------------------------------------
  always_comb begin
    dec_type  = request.request_value[15:8];
    dec_index = request.request_value[7:0];
    dec_id    = DESC_DEVICE;
    dec_known = 1'b0;
    if (request.request_code == REQ_GET_DESCRIPTOR) begin
      if (dec_type == DT_DEVICE) begin
        dec_id    = DESC_DEVICE;
        dec_known = 1'b1;
      end else if (dec_type == DT_CONFIG) begin
        dec_id    = DESC_CONFIG;
        dec_known = 1'b1;
      end else if (dec_type == DT_STRING && dec_index <= STR_INDEX_MAX) begin
        dec_id    = desc_id_t'(3'(DESC_STR_LANG) + dec_index[2:0]);
        dec_known = 1'b1;
      end
    end
    dec_size  = desc_size(dec_id);
    // bytes sent = min(descriptor size, wLength)
    dec_total = (request.request_length < 16'(dec_size))
                ? request.request_length[POS_W-1:0] : dec_size;
  end

  // ---------------------------------------------------------------------
  // Beat formation: up to BYTES_PER_BEAT bytes, cut at MAX_RESULTS beats
  // ---------------------------------------------------------------------
  always_comb begin
    nbytes    = (remain > BPB) ? CNT_W'(BYTES_PER_BEAT) : CNT_W'(remain);
    beat_last = (remain <= BPB) || (beat_cnt == BEAT_W'(MAX_RESULTS - 1));
  end

  // ---------------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (request_valid) begin
          state_next = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (load && beat_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM: outputs. A new request is taken while the last beat still waits.
  always_comb begin
    request_ready = 1'b0;
    load          = 1'b0;
    case (state)
      ST_IDLE:   request_ready = 1'b1;
      ST_STREAM: load = !response_valid || response_ready;
      default: begin
        request_ready = 1'b0;
        load          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      stored_address <= '0;
    end else begin
      state <= state_next;
      if (req_fire && request.request_code == REQ_SET_ADDRESS) begin
        stored_address <= request.request_value[6:0];
      end
    end
  end

  // Request context
  always_ff @(posedge clk) begin
    if (req_fire) begin
      id       <= dec_id;
      pos      <= '0;
      beat_cnt <= '0;
      remain   <= dec_known ? dec_total : '0;
      if (request.request_code == REQ_SET_ADDRESS) begin
        kind <= KIND_ADDR;
      end else if (dec_known) begin
        kind <= KIND_DATA;
      end else begin
        kind <= KIND_UNSUP;
      end
    end else if (load) begin
      pos      <= pos + pos_t'(nbytes);
      remain   <= remain - pos_t'(nbytes);
      beat_cnt <= beat_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Response register; data word is the ROM read register loaded alongside
  // ---------------------------------------------------------------------
  usrr_desc_rom #(
    .BYTES_PER_BEAT(BYTES_PER_BEAT)
  ) u_rom (
    .clk      (clk),
    .en       (load),
    .id       (id),
    .pos      (pos),
    .nbytes   (nbytes),
    .data_word(rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      response_valid <= 1'b0;
    end else if (load) begin
      response_valid <= 1'b1;
    end else if (response_ready) begin
      response_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_kind  <= kind;
      rsp_count <= 3'(nbytes);
      rsp_last  <= beat_last;
      rsp_addr  <= stored_address;   // address after this request's update
    end
  end

  always_comb begin
    response.response_kind  = rsp_kind;
    response.data_word      = rom_data;
    response.byte_count     = rsp_count;
    response.last_beat      = rsp_last;
    response.device_address = rsp_addr;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `USRR_ASSERT_IMPL(a_beat_limit, clk, rst, state == ST_STREAM,
                    beat_cnt < BEAT_W'(MAX_RESULTS))
  `USRR_ASSERT_NEXT(a_last_ends, clk, rst, load && beat_last, state == ST_IDLE)
  `USRR_ASSERT_IMPL(a_data_kind, clk, rst, response_valid && response.byte_count != 3'd0,
                    response.response_kind == KIND_DATA)
  `USRR_ASSERT_NEXT(a_set_addr, clk, rst,
                    req_fire && request.request_code == REQ_SET_ADDRESS,
                    stored_address == $past(request.request_value[6:0]))

endmodule

`default_nettype wire

// File: test/usrr_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the USB standard request responder: predicts the beats
// of every accepted setup request and compares them with the response channel.
// Depends on usrr_pkg for the transaction types and the request/type codes.
module usrr_response_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  input  logic           request_ready,
  input  usrr_pkg::req_t request,
  input  logic           response_valid,
  input  logic           response_ready,
  input  usrr_pkg::rsp_t response,
  output int             mismatches,
  output int             pending,
  output int             requests_seen,
  output int             beats_seen
);
  import usrr_pkg::*;

  localparam int unsigned BEAT_BYTES = 4;
  localparam int MAX_REPORTS = 10;

  // Descriptor contents, byte for byte.
  logic [7:0] device_rom [18] = '{
    8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00, 8'h40, 8'h50, 8'h1d,
    8'ha7, 8'h60, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01
  };
  logic [7:0] config_rom [67] = '{
    8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0,
    8'h32, 8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02,
    8'h01, 8'h00, 8'h05, 8'h24, 8'h00, 8'h10, 8'h01, 8'h05,
    8'h24, 8'h01, 8'h00, 8'h01, 8'h04, 8'h24, 8'h02, 8'h02,
    8'h05, 8'h24, 8'h06, 8'h00, 8'h01, 8'h07, 8'h05, 8'h82,
    8'h03, 8'h08, 8'h00, 8'hFF, 8'h09, 8'h04, 8'h01, 8'h00,
    8'h02, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h07, 8'h05, 8'h01,
    8'h02, 8'h40, 8'h00, 8'h00, 8'h07, 8'h05, 8'h81, 8'h02,
    8'h40, 8'h00, 8'h00
  };
  // String tables as 16-bit words, low byte goes out first.
  logic [15:0] lang_words [2] = '{16'h0304, 16'h0409};
  logic [15:0] manu_words [15] = '{
    16'h031E, 16'h4F, 16'h70, 16'h65, 16'h6E, 16'h6D, 16'h6F, 16'h6B, 16'h6F,
    16'h2C, 16'h20, 16'h49, 16'h6E, 16'h63, 16'h2E
  };
  logic [15:0] prod_words [23] = '{
    16'h0332, 16'h48, 16'h79, 16'h64, 16'h72, 16'h61, 16'h42, 16'h75, 16'h73,
    16'h20, 16'h31, 16'h2E, 16'h30, 16'h20, 16'h43, 16'h4F, 16'h4D, 16'h20,
    16'h50, 16'h6F, 16'h72, 16'h74, 16'h32
  };
  logic [15:0] serial_words [25] = '{
    16'h0336, 16'h30, 16'h30, 16'h33, 16'h37, 16'h30, 16'h30, 16'h31, 16'h45,
    16'h33, 16'h34, 16'h33, 16'h36, 16'h35, 16'h31, 16'h31, 16'h31, 16'h33,
    16'h39, 16'h33, 16'h33, 16'h33, 16'h34, 16'h33, 16'h34
  };
  logic [15:0] cfgstr_words [3] = '{16'h0306, 16'h30, 16'h31};

  logic [6:0] address_shadow = '0;
  rsp_t       expected_beats [$];

  function automatic int unsigned descriptor_length(desc_id_t id);
    case (id)
      DESC_DEVICE:     return 18;
      DESC_CONFIG:     return 67;
      DESC_STR_LANG:   return 4;
      DESC_STR_MANU:   return 30;
      DESC_STR_PROD:   return 46;
      DESC_STR_SERIAL: return 50;
      DESC_STR_CONFIG: return 6;
      default:         return 0;
    endcase
  endfunction

  function automatic logic [7:0] descriptor_byte(desc_id_t id, int unsigned pos);
    logic [15:0] w;
    int unsigned k;
    k = pos / 2;
    w = '0;
    case (id)
      DESC_DEVICE:     return (pos < 18) ? device_rom[pos] : 8'h00;
      DESC_CONFIG:     return (pos < 67) ? config_rom[pos] : 8'h00;
      DESC_STR_LANG:   if (k < 2) w = lang_words[k];
      DESC_STR_MANU:   if (k < 15) w = manu_words[k];
      DESC_STR_PROD:   if (k < 23) w = prod_words[k];
      DESC_STR_SERIAL: if (k < 25) w = serial_words[k];
      DESC_STR_CONFIG: if (k < 3) w = cfgstr_words[k];
      default:         w = '0;
    endcase
    return pos[0] ? w[15:8] : w[7:0];
  endfunction

  function automatic void queue_empty_packet(logic [1:0] kind);
    rsp_t b;
    b.response_kind  = kind;
    b.data_word      = '0;
    b.byte_count     = '0;
    b.last_beat      = 1'b1;
    b.device_address = address_shadow;
    expected_beats.push_back(b);
  endfunction

  // Expected beats of one setup request; updates the address shadow.
  function automatic void answer_request(req_t r);
    logic [7:0]  dtype;
    logic [7:0]  dindex;
    desc_id_t    id;
    int unsigned total;
    int unsigned sent;
    int unsigned beats;
    int unsigned n;
    rsp_t        b;
    dtype  = r.request_value[15:8];
    dindex = r.request_value[7:0];
    if (r.request_code == REQ_SET_ADDRESS) begin
      address_shadow = r.request_value[6:0];
      queue_empty_packet(KIND_ADDR);
      return;
    end
    if (r.request_code != REQ_GET_DESCRIPTOR) begin
      queue_empty_packet(KIND_UNSUP);
      return;
    end
    if (dtype == DT_DEVICE) begin
      id = DESC_DEVICE;
    end else if (dtype == DT_CONFIG) begin
      id = DESC_CONFIG;
    end else if (dtype == DT_STRING && dindex <= STR_INDEX_MAX) begin
      id = desc_id_t'(3'(DESC_STR_LANG) + dindex[2:0]);
    end else begin
      queue_empty_packet(KIND_UNSUP);
      return;
    end
    total = descriptor_length(id);
    if (r.request_length < total) total = r.request_length;
    if (total == 0) begin
      queue_empty_packet(KIND_DATA);
      return;
    end
    beats = (total + BEAT_BYTES - 1) / BEAT_BYTES;
    if (beats > MAX_RESULTS) beats = MAX_RESULTS;
    sent = 0;
    for (int unsigned bi = 0; bi < beats; bi++) begin
      n = total - sent;
      if (n > BEAT_BYTES) n = BEAT_BYTES;
      b.response_kind = KIND_DATA;
      b.data_word     = '0;
      for (int unsigned i = 0; i < n; i++) begin
        b.data_word[8*i +: 8] = descriptor_byte(id, sent + i);
      end
      b.byte_count     = 3'(n);
      b.last_beat      = (bi + 1 == beats);
      b.device_address = address_shadow;
      sent += n;
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void check_beat(rsp_t got);
    rsp_t want;
    beats_seen++;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] response beat with nothing pending: %h", $time, got);
      end
      return;
    end
    want = expected_beats.pop_front();
    if (got.response_kind !== want.response_kind || got.data_word !== want.data_word ||
        got.byte_count !== want.byte_count || got.last_beat !== want.last_beat ||
        got.device_address !== want.device_address) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] beat %0d exp/got: kind %0d/%0d data %h/%h count %0d/%0d",
                 $time, beats_seen, want.response_kind, got.response_kind,
                 want.data_word, got.data_word, want.byte_count, got.byte_count);
        $display("    last %0b/%0b addr %0d/%0d", want.last_beat, got.last_beat,
                 want.device_address, got.device_address);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      address_shadow = '0;
      expected_beats.delete();
    end else begin
      if (request_valid && request_ready) begin
        requests_seen++;
        answer_request(request);
      end
      if (response_valid && response_ready) check_beat(response);
    end
    pending = expected_beats.size();
  end

endmodule

// File: test/tb_usb_standard_request_responder_unit.sv
`timescale 1ns / 1ps
// Testbench top for the USB standard request responder: directed and random
// setup requests with random idling on both channels, and the final verdict.
// Depends on usrr_pkg, the responder RTL and usrr_response_checker.
module tb_usb_standard_request_responder_unit;
  import usrr_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 136;
  localparam int unsigned MAX_WAIT        = 18;
  localparam int unsigned DRAIN_CYCLES    = 40;
  // Worst case is ~160 requests x 17 beats, each beat after the longest stall; allow several times that.
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic clk            = 1'b0;
  logic rst            = 1'b1;
  logic request_valid  = 1'b0;
  logic request_ready;
  req_t request        = '0;
  logic response_valid;
  logic response_ready = 1'b0;
  rsp_t response;

  int mismatches;
  int pending;
  int requests_seen;
  int beats_seen;

  // When set, neither side idles: back-to-back stretches.
  bit          quiet  = 1'b0;
  int unsigned cycles = 0;

  always #6 clk = ~clk;

  usb_standard_request_responder_unit uut (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request_valid),
    .request_ready  (request_ready),
    .request        (request),
    .response_valid (response_valid),
    .response_ready (response_ready),
    .response       (response)
  );

  usrr_response_checker resp_check (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request_valid),
    .request_ready  (request_ready),
    .request        (request),
    .response_valid (response_valid),
    .response_ready (response_ready),
    .response       (response),
    .mismatches     (mismatches),
    .pending        (pending),
    .requests_seen  (requests_seen),
    .beats_seen     (beats_seen)
  );

  // Idle cycles before the next transaction on either side. Half the time
  // none, otherwise short or up to the full range.
  function automatic int unsigned draw_wait();
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 4);
      default: return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  // Drives one request at the falling edge and holds it until accepted.
  // Valid stays high on exit so a zero-gap follower goes out back to back.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      request_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request       = r;
    request_valid = 1'b1;
    do @(posedge clk); while (!request_ready);
    @(negedge clk);
  endtask

  task automatic ask(input logic [7:0] code, input logic [15:0] value,
                     input logic [15:0] length);
    req_t r;
    r.request_code   = code;
    r.request_value  = value;
    r.request_length = length;
    send_request(r);
  endtask

  // Sender holds off until every predicted beat has come back; the last
  // request is already taken, so valid drops first.
  task automatic wait_until_drained();
    request_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly well-formed descriptor requests with random lengths, then address
  // writes, then bad types and indexes, and some plain noise.
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    r.request_code   = 8'($urandom);
    r.request_value  = 16'($urandom);
    r.request_length = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      r.request_code = REQ_GET_DESCRIPTOR;
      case ($urandom_range(0, 2))
        0: r.request_value[15:8] = DT_DEVICE;
        1: r.request_value[15:8] = DT_CONFIG;
        default: begin
          r.request_value[15:8] = DT_STRING;
          r.request_value[7:0]  = 8'($urandom_range(0, STR_INDEX_MAX));
        end
      endcase
      // Short lengths cut descriptors at every byte position.
      if ($urandom_range(0, 1) == 0) r.request_length = 16'($urandom_range(0, 80));
    end else if (roll < 75) begin
      r.request_code = REQ_SET_ADDRESS;
    end else if (roll < 85) begin
      r.request_code = REQ_GET_DESCRIPTOR;
    end
    return r;
  endfunction

  // Sink side: random stall before each beat, ready then held until a beat
  // is taken.
  initial begin : sink
    int unsigned stall;
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        response_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      response_ready = 1'b1;
      do @(posedge clk); while (!response_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every descriptor, every unsupported path.
    ask(REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF);         // high bits of wValue dropped
    ask(REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'hFF}, 16'hFFFF); // index ignored
    ask(REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'hFFFF); // longest response
    for (int i = 0; i <= STR_INDEX_MAX; i++) begin
      ask(REQ_GET_DESCRIPTOR, {DT_STRING, 8'(i)}, 16'hFFFF);
    end
    ask(REQ_GET_DESCRIPTOR, {DT_STRING, STR_INDEX_MAX + 8'd1}, 16'hFFFF);
    ask(REQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, 16'h0040);
    ask(REQ_GET_DESCRIPTOR, {8'h00, 8'h00}, 16'h0012);
    ask(REQ_GET_DESCRIPTOR, {DT_STRING + 8'd1, 8'h00}, 16'h0012);
    ask(REQ_GET_DESCRIPTOR, {8'hFF, 8'hFF}, 16'h0000);
    ask(REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000); // zero wLength: empty data
    ask(REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'd1);
    ask(REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'd66);
    ask(REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'd5);
    ask(8'h00, 16'h0000, 16'h0000);
    ask(8'hFF, 16'hFFFF, 16'hFFFF);
    ask(REQ_GET_DESCRIPTOR + 8'd1, {DT_DEVICE, 8'h00}, 16'hFFFF);
    ask(REQ_SET_ADDRESS - 8'd1, {DT_DEVICE, 8'h00}, 16'hFFFF);
    ask(REQ_SET_ADDRESS, 16'h0080, 16'h0000);          // bit 7 only: address 0
    ask(REQ_SET_ADDRESS, 16'h002A, 16'h0012);
    ask(REQ_GET_DESCRIPTOR, {DT_STRING, 8'd2}, 16'd7); // cut inside a string word

    // Sender waits for the full drain before the random part.
    wait_until_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_REQUESTS / 2 || $urandom_range(0, 39) == 0) wait_until_drained();
      send_request(random_request());
    end
    request_valid = 1'b0;

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d setup requests and %0d response beats", requests_seen, beats_seen);
    $display("address writes, all descriptors with cut lengths, unsupported codes");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/usrr_pkg.sv
rtl/usrr_desc_rom.sv
rtl/usb_standard_request_responder_unit.sv
test/usrr_response_checker.sv
test/tb_usb_standard_request_responder_unit.sv
